[rtl/core/scbp_pkg.sv]
`timescale 1ns / 1ps

package scbp_pkg;

    localparam int LENW        = 32;
    localparam int CNTW        = 10;
    localparam int FIDXW       = 9;
    localparam int FCLSW       = 2;
    localparam int CFG_CLASSES = 4;
    localparam int CFG_IDXW    = 3;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 24;

    typedef enum logic [CFG_IDXW-1:0] {
        REG_LEN0,
        REG_LEN1,
        REG_LEN2,
        REG_LEN3,
        REG_CNT0,
        REG_CNT1,
        REG_CNT2,
        REG_CNT3
    } t_reg_idx;

    typedef enum logic {
        ACT_ALLOC,
        ACT_FREE
    } t_action;

    typedef enum logic [1:0] {
        ST_GRANT,
        ST_FALLBACK,
        ST_FREED,
        ST_IGNORED
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_POP,
        S_FCHK
    } t_state;

    typedef struct packed {
        logic [CFG_CLASSES-1:0][LENW-1:0] len;
        logic [CFG_CLASSES-1:0][CNTW-1:0] count;
        logic                             clear;
    } t_cfg;

    typedef struct packed {
        t_action             action;
        logic [LENW-1:0]     size;
        logic                fb;
        logic [FCLSW-1:0]    cls;
        logic [FIDXW-1:0]    idx;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [FCLSW-1:0]    cls;
        logic [FIDXW-1:0]    idx;
        logic [CNTW-1:0]     used;
    } t_res;

endpackage

[rtl/core/size_class_block_pool_top.sv]
`timescale 1ns / 1ps

// Block pool with up to four size classes. Each request is an allocate (tuser 0) or a free
// (tuser 1) and yields exactly one result. A request is taken in S_IDLE and evaluated in
// S_EVAL; a fallback answer, an ignored free or a grant of a never-used block completes
// there. A grant that reuses a freed block and a free that passes the range checks go on
// to S_POP or S_FCHK, since the freed-index stack or the in-use map, each a single-port
// memory with registered read data, must be read first. A new request is taken while the
// previous result still waits in the output register. A configuration
// write takes effect at once and empties every class in the same cycle; no clearing pass
// runs, since a block at or above a class's never-used mark counts as free.
module size_class_block_pool_top #(
    parameter int NUM_CLASSES = 4,
    parameter int MAX_BLOCKS  = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request: [31:0] request_size, [32] free_fallback, [34:33] free_class,
    // [43:35] free_index, [47:44] zero
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [scbp_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser, // [0] action
    // result: [1:0] granted_class, [10:2] granted_index, [20:11] class_in_use, [23:21] zero
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [scbp_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]                     o_m_tuser, // [1:0] status
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scbp_pkg::CFG_IDXW-1:0]  i_cfg_index,
    input  logic [scbp_pkg::LENW-1:0]      i_cfg_data
);
    import scbp_pkg::*;

    t_cfg cfg;
    t_req req;
    t_res res;

    assign req.action = t_action'(i_s_tuser);
    assign req.size   = i_s_tdata[31:0];
    assign req.fb     = i_s_tdata[32];
    assign req.cls    = i_s_tdata[34:33];
    assign req.idx    = i_s_tdata[43:35];

    assign o_m_tdata = {3'b000, res.used, res.idx, res.cls};
    assign o_m_tuser = res.status;

    scbp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    scbp_ctrl #(
        .NUM_CLASSES (NUM_CLASSES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_req      (req),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (res)
    );

endmodule

[rtl/core/scbp_cfg.sv]
`timescale 1ns / 1ps

module scbp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scbp_pkg::CFG_IDXW-1:0] i_cfg_index,
    input  logic [scbp_pkg::LENW-1:0]     i_cfg_data,
    output scbp_pkg::t_cfg                o_cfg
);
    import scbp_pkg::*;

    logic [CFG_CLASSES-1:0][LENW-1:0] r_len;
    logic [CFG_CLASSES-1:0][CNTW-1:0] r_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                [REG_LEN0:REG_LEN3]: begin
                    r_len[i_cfg_index[1:0]] <= i_cfg_data;
                end
                [REG_CNT0:REG_CNT3]: begin
                    r_count[i_cfg_index[1:0]] <= i_cfg_data[CNTW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // every register write wipes the pool state
    assign o_cfg.len   = r_len;
    assign o_cfg.count = r_count;
    assign o_cfg.clear = i_cfg_valid;

endmodule

[rtl/core/scbp_ctrl.sv]
`timescale 1ns / 1ps

module scbp_ctrl #(
    parameter int NUM_CLASSES = 4,
    parameter int MAX_BLOCKS  = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scbp_pkg::t_cfg i_cfg,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  scbp_pkg::t_req i_req,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output scbp_pkg::t_res o_res
);
    import scbp_pkg::*;

    localparam int IDXW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CLSW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW    = CLSW + IDXW;
    localparam int DEPTH = NUM_CLASSES * (2 ** IDXW);
    localparam logic [CNTW-1:0] CLAMP =
        (MAX_BLOCKS < (2 ** CNTW)) ? CNTW'(MAX_BLOCKS) : '1;

    t_state          r_state, n_state;
    t_req            r_req;
    logic [CLSW-1:0] r_sel, n_sel;
    logic [CNTW-1:0] r_depth [NUM_CLASSES];
    logic [CNTW-1:0] n_depth [NUM_CLASSES];
    logic [CNTW-1:0] r_fresh [NUM_CLASSES];
    logic [CNTW-1:0] n_fresh [NUM_CLASSES];
    logic            r_o_valid;
    t_res            r_res, n_res;
    logic            load;
    logic            out_free;
    logic            accept;

    // freed-index stacks and in-use map, single port each
    logic [IDXW-1:0] r_stk_mem [DEPTH];
    logic [IDXW-1:0] r_stk_q;
    logic            r_map_mem [DEPTH];
    logic            r_map_q;
    logic            stk_en, stk_we;
    logic [AW-1:0]   stk_addr;
    logic [IDXW-1:0] stk_wdata;
    logic            map_en, map_we;
    logic [AW-1:0]   map_addr;
    logic            map_wdata;

    logic [CNTW-1:0] eff [NUM_CLASSES];
    logic            fit [NUM_CLASSES];
    logic            any_fit;
    logic [CLSW-1:0] fit_cls;
    logic            too_big;
    logic [CLSW-1:0] fcl;
    logic            free_ok;

    assign out_free   = !r_o_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_o_valid;
    assign o_res      = r_res;

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            eff[c] = (MAX_BLOCKS < (2 ** CNTW) && i_cfg.count[c] > MAX_BLOCKS) ?
                     CLAMP : i_cfg.count[c];
            fit[c] = (r_req.size <= i_cfg.len[c]) && ((r_fresh[c] - r_depth[c]) < eff[c]);
        end
        any_fit = 1'b0;
        fit_cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (fit[c]) begin
                any_fit = 1'b1;
                fit_cls = CLSW'(c);
            end
        end
        too_big = r_req.size > i_cfg.len[NUM_CLASSES-1];
        fcl     = CLSW'(r_req.cls);
        // an index at or above r_fresh was never handed out since the last clear
        free_ok = !r_req.fb && (r_req.cls < NUM_CLASSES) && (r_req.idx < eff[fcl])
                  && (r_req.idx < r_fresh[fcl]) && (r_depth[fcl] < MAX_BLOCKS);
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_depth    = r_depth;
        n_fresh    = r_fresh;
        stk_en     = 1'b0;
        stk_we     = 1'b0;
        stk_addr   = '0;
        stk_wdata  = '0;
        map_en     = 1'b0;
        map_we     = 1'b0;
        map_addr   = '0;
        map_wdata  = 1'b0;
        load       = 1'b0;
        n_res      = '0;
        n_res.status = ST_FALLBACK;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    if (r_req.action == ACT_ALLOC) begin
                        if (too_big || !any_fit) begin
                            load    = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_depth[fit_cls] != '0) begin
                            n_depth[fit_cls] = r_depth[fit_cls] - 1'b1;
                            stk_en   = 1'b1;
                            stk_addr = {fit_cls, IDXW'(r_depth[fit_cls] - 1'b1)};
                            n_sel    = fit_cls;
                            n_state  = S_POP;
                        end else begin
                            n_fresh[fit_cls] = r_fresh[fit_cls] + 1'b1;
                            map_en       = 1'b1;
                            map_we       = 1'b1;
                            map_addr     = {fit_cls, IDXW'(r_fresh[fit_cls])};
                            map_wdata    = 1'b1;
                            load         = 1'b1;
                            n_res.status = ST_GRANT;
                            n_res.cls    = FCLSW'(fit_cls);
                            n_res.idx    = FIDXW'(r_fresh[fit_cls]);
                            n_res.used   = r_fresh[fit_cls] + 1'b1 - r_depth[fit_cls];
                            n_state      = S_IDLE;
                        end
                    end else if (free_ok) begin
                        map_en   = 1'b1;
                        map_addr = {fcl, IDXW'(r_req.idx)};
                        n_sel    = fcl;
                        n_state  = S_FCHK;
                    end else begin
                        load         = 1'b1;
                        n_res.status = ST_IGNORED;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    map_en       = 1'b1;
                    map_we       = 1'b1;
                    map_addr     = {r_sel, r_stk_q};
                    map_wdata    = 1'b1;
                    load         = 1'b1;
                    n_res.status = ST_GRANT;
                    n_res.cls    = FCLSW'(r_sel);
                    n_res.idx    = FIDXW'(r_stk_q);
                    n_res.used   = r_fresh[r_sel] - r_depth[r_sel];
                    n_state      = S_IDLE;
                end
            end
            S_FCHK: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                    if (r_map_q) begin
                        n_depth[r_sel] = r_depth[r_sel] + 1'b1;
                        map_en       = 1'b1;
                        map_we       = 1'b1;
                        map_addr     = {r_sel, IDXW'(r_req.idx)};
                        stk_en       = 1'b1;
                        stk_we       = 1'b1;
                        stk_addr     = {r_sel, IDXW'(r_depth[r_sel])};
                        stk_wdata    = IDXW'(r_req.idx);
                        n_res.status = ST_FREED;
                        n_res.cls    = FCLSW'(r_sel);
                        n_res.idx    = r_req.idx;
                        n_res.used   = r_fresh[r_sel] - r_depth[r_sel] - 1'b1;
                    end else begin
                        n_res.status = ST_IGNORED;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_depth[c] <= '0;
                r_fresh[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_depth[c] <= i_cfg.clear ? '0 : n_depth[c];
                r_fresh[c] <= i_cfg.clear ? '0 : n_fresh[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        if (accept) begin
            r_req <= i_req;
        end
        if (load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_en) begin
            if (stk_we) begin
                r_stk_mem[stk_addr] <= stk_wdata;
            end else begin
                r_stk_q <= r_stk_mem[stk_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_en) begin
            if (map_we) begin
                r_map_mem[map_addr] <= map_wdata;
            end else begin
                r_map_q <= r_map_mem[map_addr];
            end
        end
    end

endmodule

[rtl/core/scbp_checker.sv]
`timescale 1ns / 1ps

module scbp_checker #(
    parameter int NUM_CLASSES = 4
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [scbp_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [1:0]                     o_m_tuser
);
    import scbp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // one request at a time: evaluation follows every accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted during evaluation");

    a_no_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FALLBACK || o_m_tuser == ST_IGNORED)
        |-> o_m_tdata == '0)
        else $error("fallback or ignored result carries block fields");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_GRANT || o_m_tuser == ST_FREED)
        |-> o_m_tdata[1:0] < NUM_CLASSES)
        else $error("granted class out of range");

endmodule

bind size_class_block_pool_top scbp_checker #(
    .NUM_CLASSES (NUM_CLASSES)
) u_scbp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[bench/size_class_block_pool_top_test.sv]
`timescale 1ns / 1ps

module size_class_block_pool_top_test;

    import scbp_pkg::*;

    localparam int POOL_CLASSES = 4;
    localparam int POOL_BLOCKS  = 512;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        bit   setup;
        t_req req;
        bit   pinned;
        t_res want;
    } t_row;

    typedef struct {
        logic [FCLSW-1:0] cls;
        logic [FIDXW-1:0] idx;
    } t_handle;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 o_m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [1:0]           o_m_tuser;
    logic                 cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDXW-1:0]  cfg_index;
    logic [LENW-1:0]      cfg_data;

    // pool model state
    logic [LENW-1:0]  class_len_q [POOL_CLASSES];
    logic [CNTW-1:0]  class_cnt_q [POOL_CLASSES];
    logic [FIDXW-1:0] freed_idx   [POOL_CLASSES][POOL_BLOCKS];
    int unsigned      freed_depth [POOL_CLASSES];
    int unsigned      never_used  [POOL_CLASSES];
    bit               busy_map    [POOL_CLASSES][POOL_BLOCKS];

    t_res    pending_results[$];
    t_handle live_blocks[$];
    t_row    directed_rows[$];

    bit   pinned_on;
    t_res pinned_want;
    bit   no_gaps;
    int   mismatches;
    int   quiet_cycles;
    t_req taken_req;
    t_res step_res;
    t_res oldest;

    size_class_block_pool_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned usable_blocks(int c);
        return (class_cnt_q[c] > POOL_BLOCKS) ? POOL_BLOCKS : int'(class_cnt_q[c]);
    endfunction

    function automatic void clear_pool();
        for (int c = 0; c < POOL_CLASSES; c++) begin
            freed_depth[c] = 0;
            never_used[c]  = 0;
            for (int b = 0; b < POOL_BLOCKS; b++)
                busy_map[c][b] = 1'b0;
        end
        live_blocks.delete();
    endfunction

    function automatic t_res make_res(t_status s, int c, int i, int u);
        t_res o;
        o.status = s;
        o.cls    = FCLSW'(c);
        o.idx    = FIDXW'(i);
        o.used   = CNTW'(u);
        return o;
    endfunction

    function automatic t_req alloc_req(logic [LENW-1:0] size);
        t_req r;
        r.action = ACT_ALLOC;
        r.size   = size;
        r.fb     = 1'b0;
        r.cls    = '0;
        r.idx    = '0;
        return r;
    endfunction

    function automatic t_req free_req(bit fb, int c, int i);
        t_req r;
        r.action = ACT_FREE;
        r.size   = '0;
        r.fb     = fb;
        r.cls    = FCLSW'(c);
        r.idx    = FIDXW'(i);
        return r;
    endfunction

    // first-fit over the classes, freed blocks reused before never-used ones
    function automatic t_res pool_step(t_req r);
        int unsigned n;
        int unsigned idx;
        int          c;
        if (r.action == ACT_ALLOC) begin
            if (r.size > class_len_q[POOL_CLASSES-1])
                return make_res(ST_FALLBACK, 0, 0, 0);
            for (c = 0; c < POOL_CLASSES; c++) begin
                n = usable_blocks(c);
                if (r.size > class_len_q[c])
                    continue;
                if (never_used[c] - freed_depth[c] >= n)
                    continue;
                if (freed_depth[c] > 0) begin
                    freed_depth[c]--;
                    idx = 32'(freed_idx[c][freed_depth[c]]);
                end else if (never_used[c] < n) begin
                    idx = never_used[c];
                    never_used[c]++;
                end else begin
                    continue;
                end
                busy_map[c][idx] = 1'b1;
                return make_res(ST_GRANT, c, int'(idx), int'(never_used[c] - freed_depth[c]));
            end
            return make_res(ST_FALLBACK, 0, 0, 0);
        end
        c = int'(r.cls);
        if (r.fb || r.idx >= usable_blocks(c) || !busy_map[c][r.idx]
                || freed_depth[c] >= POOL_BLOCKS)
            return make_res(ST_IGNORED, 0, 0, 0);
        busy_map[c][r.idx] = 1'b0;
        freed_idx[c][freed_depth[c]] = r.idx;
        freed_depth[c]++;
        return make_res(ST_FREED, c, int'(r.idx), int'(never_used[c] - freed_depth[c]));
    endfunction

    task automatic note_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("result with no request pending");
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("status", 32'(o_m_tuser), 32'(oldest.status));
                    check_field("class", 32'(o_m_tdata[1:0]), 32'(oldest.cls));
                    check_field("index", 32'(o_m_tdata[10:2]), 32'(oldest.idx));
                    check_field("in_use", 32'(o_m_tdata[20:11]), 32'(oldest.used));
                end
            end
            if (cfg_valid && o_cfg_ready) begin
                if (cfg_index < REG_CNT0)
                    class_len_q[cfg_index] = cfg_data;
                else
                    class_cnt_q[cfg_index - REG_CNT0] = cfg_data[CNTW-1:0];
                clear_pool();
            end
            if (s_tvalid && o_s_tready) begin
                taken_req.action = t_action'(s_tuser);
                taken_req.size   = s_tdata[31:0];
                taken_req.fb     = s_tdata[32];
                taken_req.cls    = s_tdata[34:33];
                taken_req.idx    = s_tdata[43:35];
                step_res = pool_step(taken_req);
                if (step_res.status == ST_GRANT) begin
                    live_blocks.push_back('{step_res.cls, step_res.idx});
                end else if (step_res.status == ST_FREED) begin
                    for (int i = 0; i < live_blocks.size(); i++) begin
                        if (live_blocks[i].cls == step_res.cls
                                && live_blocks[i].idx == step_res.idx) begin
                            live_blocks.delete(i);
                            break;
                        end
                    end
                end
                pending_results.push_back(pinned_on ? pinned_want : step_res);
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[size_class_block_pool_top] ERROR");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 13);
    endfunction

    initial begin
        int gap;
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic send_request(t_req r, bit pin, t_res want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid    = 1'b1;
        s_tdata     = {4'b0, r.idx, r.cls, r.fb, r.size};
        s_tuser     = r.action;
        pinned_on   = pin;
        pinned_want = want;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // let the last request drain before touching the registers
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic program_pool(logic [LENW-1:0] lens[POOL_CLASSES],
                                logic [CNTW-1:0] cnts[POOL_CLASSES]);
        t_reg_idx r;
        for (int k = 0; k < 2 * POOL_CLASSES; k++) begin
            r = t_reg_idx'(k);
            cfg_valid = 1'b1;
            cfg_index = r;
            if (r < REG_CNT0)
                cfg_data = lens[k];
            else if ($urandom_range(0, 1))
                cfg_data = {22'($urandom), cnts[k - POOL_CLASSES]};
            else
                cfg_data = {22'b0, cnts[k - POOL_CLASSES]};
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        cfg_valid = 1'b0;
    endtask

    task automatic random_item(int alloc_pct);
        t_req    r;
        int      k;
        t_handle h;
        r.size = $urandom;
        r.fb   = 1'($urandom_range(0, 1));
        r.cls  = FCLSW'($urandom_range(0, 3));
        r.idx  = FIDXW'($urandom_range(0, POOL_BLOCKS - 1));
        if ($urandom_range(0, 99) < alloc_pct) begin
            r.action = ACT_ALLOC;
            k = $urandom_range(0, POOL_CLASSES - 1);
            case ($urandom_range(0, 5))
                0: r.size = class_len_q[k];
                1: r.size = class_len_q[k] - 1;
                2: r.size = class_len_q[k] + 1;
                3: r.size = $urandom;
                4: r.size = '0;
                default: r.size = $urandom_range(0, class_len_q[k]);
            endcase
        end else begin
            r.action = ACT_FREE;
            if (live_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
                h = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                r.fb  = 1'b0;
                r.cls = h.cls;
                r.idx = h.idx;
            end else if ($urandom_range(0, 1)) begin
                r.idx = FIDXW'($urandom_range(0, 7));
            end
        end
        send_request(r, 1'b0, '0);
    endtask

    initial begin
        logic [LENW-1:0] lens[POOL_CLASSES];
        logic [CNTW-1:0] cnts[POOL_CLASSES];
        int unsigned     base;
        int              alloc_pct;

        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_LEN0;
        cfg_data    = '0;
        pinned_on   = 1'b0;
        pinned_want = '0;
        no_gaps     = 1'b0;
        mismatches  = 0;
        for (int c = 0; c < POOL_CLASSES; c++) begin
            class_len_q[c] = '0;
            class_cnt_q[c] = '0;
        end
        clear_pool();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // out of reset every class is empty; then 16/256/4096/max bytes
        // with 2, 1, none and an over-limit count
        directed_rows.push_back('{0, alloc_req(0), 1, make_res(ST_FALLBACK, 0, 0, 0)});
        directed_rows.push_back('{0, alloc_req('1), 1, make_res(ST_FALLBACK, 0, 0, 0)});
        directed_rows.push_back('{0, free_req(0, 0, 0), 1, make_res(ST_IGNORED, 0, 0, 0)});
        directed_rows.push_back('{0, free_req(1, 3, 511), 1, make_res(ST_IGNORED, 0, 0, 0)});
        directed_rows.push_back('{1, alloc_req(0), 0, make_res(ST_GRANT, 0, 0, 1)});
        directed_rows.push_back('{0, alloc_req(16), 0, make_res(ST_GRANT, 0, 1, 2)});
        directed_rows.push_back('{0, alloc_req(1), 0, make_res(ST_GRANT, 1, 0, 1)});
        directed_rows.push_back('{0, alloc_req(17), 0, make_res(ST_GRANT, 3, 0, 1)});
        directed_rows.push_back('{0, alloc_req('1), 0, make_res(ST_GRANT, 3, 1, 2)});
        directed_rows.push_back('{0, free_req(0, 0, 1), 0, make_res(ST_FREED, 0, 1, 1)});
        directed_rows.push_back('{0, free_req(0, 0, 0), 0, make_res(ST_FREED, 0, 0, 0)});
        directed_rows.push_back('{0, free_req(0, 0, 0), 1, make_res(ST_IGNORED, 0, 0, 0)});
        directed_rows.push_back('{0, alloc_req(5), 0, make_res(ST_GRANT, 0, 0, 1)});
        directed_rows.push_back('{0, alloc_req(5), 0, make_res(ST_GRANT, 0, 1, 2)});
        directed_rows.push_back('{0, free_req(1, 0, 0), 1, make_res(ST_IGNORED, 0, 0, 0)});
        directed_rows.push_back('{0, free_req(0, 2, 0), 1, make_res(ST_IGNORED, 0, 0, 0)});
        directed_rows.push_back('{0, free_req(0, 3, 511), 1, make_res(ST_IGNORED, 0, 0, 0)});
        directed_rows.push_back('{0, free_req(0, 0, 511), 1, make_res(ST_IGNORED, 0, 0, 0)});
        directed_rows.push_back('{0, free_req(0, 1, 0), 0, make_res(ST_FREED, 1, 0, 0)});
        directed_rows.push_back('{0, alloc_req(300), 0, make_res(ST_GRANT, 3, 2, 3)});

        foreach (directed_rows[i]) begin
            if (directed_rows[i].setup) begin
                wait_idle();
                lens = '{32'd16, 32'd256, 32'd4096, 32'hFFFF_FFFF};
                cnts = '{10'd2, 10'd1, 10'd0, 10'd1023};
                program_pool(lens, cnts);
            end
            send_request(directed_rows[i].req, directed_rows[i].pinned,
                         directed_rows[i].want);
        end

        // fill the only class past the block limit so it runs dry
        wait_idle();
        lens = '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};
        cnts = '{10'd0, 10'd0, 10'd0, 10'd1023};
        program_pool(lens, cnts);
        for (int n = 0; n < 560; n++) begin
            if (n % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            random_item(99);
        end

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            if ($urandom_range(0, 3) != 0) begin
                base = $urandom_range(0, 32);
                for (int c = 0; c < POOL_CLASSES; c++) begin
                    lens[c] = base;
                    base += $urandom_range(1, 200);
                end
                if ($urandom_range(0, 2) == 0)
                    lens[POOL_CLASSES-1] = '1;
            end else begin
                // lengths out of order
                for (int c = 0; c < POOL_CLASSES; c++)
                    lens[c] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400);
            end
            for (int c = 0; c < POOL_CLASSES; c++) begin
                case ($urandom_range(0, 9))
                    0: cnts[c] = 10'd0;
                    1: cnts[c] = 10'd512;
                    2: cnts[c] = CNTW'($urandom_range(513, 1023));
                    default: cnts[c] = CNTW'($urandom_range(1, 6));
                endcase
            end
            program_pool(lens, cnts);
            alloc_pct = $urandom_range(45, 75);
            for (int n = 0; n < 110; n++) begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                random_item(alloc_pct);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[size_class_block_pool_top] OK");
        else
            $display("[size_class_block_pool_top] ERROR");
        $finish;
    end

endmodule
